// ===== sv/b64lw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, character constants and the alphabet lookup for the
// line-wrapping base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

	// Most characters one input beat can cause: one group plus CR LF.
	localparam int MAX_CHARS = 6;
	localparam int CNT_W     = 3;

	localparam logic [7:0] CHAR_CR  = 8'd13;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_PAD = 8'h3d;

	// Characters caused by one input beat, ready to be sent one per cycle while the output is ready.
	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [CNT_W-1:0]          n;
		logic                      msg_end;
	} burst_t;

	// Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			r = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			r = 8'h2b;
		end else begin
			r = 8'h2f;
		end
		return r;
	endfunction

endpackage

// ===== sv/b64lw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_if
// Valid/ready channels of the encoder: the byte input and the character
// output.
// ----------------------------------------------------------------------------
interface b64lw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;

	modport source (output valid, output data_byte, output byte_valid, output last,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input last,
		output ready);
endinterface

interface b64lw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       message_end;

	modport source (output valid, output out_char, output run_last,
		output message_end, input ready);
	modport sink (input valid, input out_char, input run_last, input message_end,
		output ready);
endinterface

// ===== sv/b64lw_encode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_encode
// Combinational step for one input beat: gathers bytes into groups, forms
// the four characters with padding, decides on line breaks and gives the
// next encoder state.
// ----------------------------------------------------------------------------
module b64lw_encode #(
	parameter int LINE_CHARS = 76,
	parameter int GW         = 5
) (
	input  logic [15:0]        pend_bytes,
	input  logic [1:0]         pend_count,
	input  logic [GW-1:0]      groups,
	input  logic               wrap,
	input  logic [7:0]         data_byte,
	input  logic               byte_valid,
	input  logic               last,
	output logic [15:0]        pend_bytes_nxt,
	output logic [1:0]         pend_count_nxt,
	output logic [GW-1:0]      groups_nxt,
	output b64lw_pkg::burst_t  burst
);
	import b64lw_pkg::*;

	localparam int GROUPS_MAX = (LINE_CHARS + 3) / 4;

	logic        has_group;
	logic [7:0]  b0, b1, b2;
	logic [1:0]  nbytes;
	logic [15:0] pb;
	logic [1:0]  pc;
	logic [23:0] t;
	logic [GW:0] g_inc;
	logic [GW-1:0] g_after;
	logic        crlf;

	// Byte gathering and end-of-message flush.
	always_comb begin
		has_group = 1'b0;
		b0 = 8'h00;
		b1 = 8'h00;
		b2 = 8'h00;
		nbytes = 2'd3;
		pb = pend_bytes;
		pc = pend_count;
		if (byte_valid) begin
			if (pend_count >= 2'd2) begin
				has_group = 1'b1;
				b0 = pend_bytes[15:8];
				b1 = pend_bytes[7:0];
				b2 = data_byte;
				nbytes = 2'd3;
				pb = 16'h0000;
				pc = 2'd0;
			end else if (pend_count == 2'd1) begin
				pb = {pend_bytes[15:8], data_byte};
				pc = 2'd2;
			end else begin
				pb = {data_byte, 8'h00};
				pc = 2'd1;
			end
		end
		if (last) begin
			if (pc == 2'd1) begin
				has_group = 1'b1;
				b0 = pb[15:8];
				nbytes = 2'd1;
			end else if (pc >= 2'd2) begin
				has_group = 1'b1;
				b0 = pb[15:8];
				b1 = pb[7:0];
				nbytes = 2'd2;
			end
			pb = 16'h0000;
			pc = 2'd0;
		end
	end

	assign pend_bytes_nxt = pb;
	assign pend_count_nxt = pc;

	// Line length tracking and CR LF decisions.
	always_comb begin
		g_inc   = {1'b0, groups} + {{GW{1'b0}}, 1'b1};
		g_after = groups;
		crlf    = 1'b0;
		if (has_group) begin
			if (wrap) begin
				if (g_inc >= (GW+1)'(GROUPS_MAX)) begin
					crlf    = 1'b1;
					g_after = '0;
				end else begin
					g_after = g_inc[GW-1:0];
				end
			end else begin
				g_after = '0;
			end
		end
		if (last) begin
			if (wrap && (g_after != '0)) begin
				crlf = 1'b1;
			end
			g_after = '0;
		end
	end

	assign groups_nxt = g_after;

	// Character burst for this beat.
	assign t = {b0, b1, b2};
	always_comb begin
		burst.chars   = '0;
		burst.msg_end = last;
		if (has_group) begin
			burst.chars[0] = b64_char(t[23:18]);
			burst.chars[1] = b64_char(t[17:12]);
			burst.chars[2] = (nbytes > 2'd1) ? b64_char(t[11:6]) : CHAR_PAD;
			burst.chars[3] = (nbytes > 2'd2) ? b64_char(t[5:0]) : CHAR_PAD;
			burst.chars[4] = CHAR_CR;
			burst.chars[5] = CHAR_LF;
			burst.n = crlf ? CNT_W'(6) : CNT_W'(4);
		end else begin
			burst.chars[0] = CHAR_CR;
			burst.chars[1] = CHAR_LF;
			burst.n = crlf ? CNT_W'(2) : CNT_W'(0);
		end
	end

endmodule

// ===== sv/base64_encoder_line_wrap_core.sv =====
`timescale 1ns / 1ps
// The first character of a beat is offered in the cycle after the beat is accepted.
// A beat causes N characters (0, 2, 4 or 6); while out_ch.ready is high the output register
// sends one character per cycle, and a new beat is taken as the last character of the
// previous one leaves.
// Reset (arst_n low, asynchronous): no pending bytes, empty line, wrapping off, output idle.
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap_core
// Streaming base64 encoder with optional CR LF line wrapping after every
// LINE_CHARS characters, rounded up to a multiple of four.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap_core #(
	parameter int LINE_CHARS = 76
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	b64lw_in_if.sink     in_ch,
	b64lw_out_if.source  out_ch
);
	import b64lw_pkg::*;

	localparam int GROUPS_MAX = (LINE_CHARS + 3) / 4;
	localparam int GW         = $clog2(GROUPS_MAX + 1);

	logic                 wrap_q;
	logic [15:0]          pend_bytes_q;
	logic [1:0]           pend_count_q;
	logic [GW-1:0]        groups_q;
	logic                 busy_q;
	logic [CNT_W-1:0]     idx_q;
	burst_t               burst_q;

	logic [15:0]          pend_bytes_nxt;
	logic [1:0]           pend_count_nxt;
	logic [GW-1:0]        groups_nxt;
	burst_t               burst_nxt;
	logic                 in_acc;
	logic                 out_acc;
	logic                 last_char;

	// Per-beat encoding step.
	b64lw_encode #(
		.LINE_CHARS (LINE_CHARS),
		.GW         (GW)
	) u_encode (
		.pend_bytes     (pend_bytes_q),
		.pend_count     (pend_count_q),
		.groups         (groups_q),
		.wrap           (wrap_q),
		.data_byte      (in_ch.data_byte),
		.byte_valid     (in_ch.byte_valid),
		.last           (in_ch.last),
		.pend_bytes_nxt (pend_bytes_nxt),
		.pend_count_nxt (pend_count_nxt),
		.groups_nxt     (groups_nxt),
		.burst          (burst_nxt)
	);

	// Handshakes: take a new beat once the current burst is done or leaving.
	assign last_char  = (idx_q == (burst_q.n - CNT_W'(1)));
	assign out_acc    = busy_q & out_ch.ready;
	assign in_ch.ready = ~busy_q | (out_ch.ready & last_char);
	assign in_acc     = in_ch.valid & in_ch.ready;

	// Output payload from the burst register.
	assign out_ch.valid       = busy_q;
	assign out_ch.out_char    = burst_q.chars[idx_q];
	assign out_ch.run_last    = last_char;
	assign out_ch.message_end = last_char & burst_q.msg_end;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= 1'b0;
		end else if (cfg_we) begin
			wrap_q <= cfg_wdata;
		end
	end

	// Encoder state and output sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bytes_q <= 16'h0000;
			pend_count_q <= 2'd0;
			groups_q     <= '0;
			busy_q       <= 1'b0;
			idx_q        <= '0;
		end else if (in_acc) begin
			pend_bytes_q <= pend_bytes_nxt;
			pend_count_q <= pend_count_nxt;
			groups_q     <= groups_nxt;
			busy_q       <= (burst_nxt.n != '0);
			idx_q        <= '0;
		end else if (out_acc) begin
			if (last_char) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// Burst payload register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			burst_q <= burst_nxt;
		end
	end

	// The character index stays inside the current burst.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < burst_q.n))
		else $error("character index beyond burst length");

	// A burst that is not finished keeps offering characters.
	a_burst_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !last_char) |=> out_ch.valid)
		else $error("burst dropped before its last character");

	// The end of the message is always the end of a beat's burst.
	a_msg_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.message_end) |-> out_ch.run_last)
		else $error("message end without run end");

	// With nothing pending on the output the input is open.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> in_ch.ready)
		else $error("input stalled while output idle");

	// At most two bytes are ever held.
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_count_q != 2'd3)
		else $error("pending byte count out of range");

endmodule
